// ===== design/slm3_pkg.sv =====
// ----------------------------------------------------------------------------
// slm3_pkg
// Shared constants for the 3x3 strict local minimum detector.
// ----------------------------------------------------------------------------
package slm3_pkg;

  // window edge length and the index of its centre
  localparam int WIN = 3;
  localparam int CTR = WIN / 2;

  // width of the configuration write data and of the reported positions
  localparam int CFG_W = 11;
  localparam int POS_W = 10;

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

endpackage

// ===== design/slm3_line_buf.sv =====
// ----------------------------------------------------------------------------
// slm3_line_buf
// Two line stores packed in one memory word: read one column, write one column.
// ----------------------------------------------------------------------------
module slm3_line_buf #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [VALUE_WIDTH-1:0]        rd_upper,
  output logic [VALUE_WIDTH-1:0]        rd_middle,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [VALUE_WIDTH-1:0]        wr_upper,
  input  logic [VALUE_WIDTH-1:0]        wr_middle
);

  logic [2*VALUE_WIDTH-1:0] mem [DEPTH];
  logic [2*VALUE_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_upper, wr_middle};
    end
  end

  // read data holds while the consumer is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_upper  = rd_data_r[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign rd_middle = rd_data_r[VALUE_WIDTH-1:0];

endmodule

// ===== design/slm3_win_cell.sv =====
// ----------------------------------------------------------------------------
// slm3_win_cell
// One window column: three samples that move one cell left on every shift.
// ----------------------------------------------------------------------------
module slm3_win_cell #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      shift_en,
  input  logic [slm3_pkg::WIN-1:0][VALUE_WIDTH-1:0] col_in,
  output logic [slm3_pkg::WIN-1:0][VALUE_WIDTH-1:0] col_out
);

  import slm3_pkg::*;

  logic [WIN-1:0][VALUE_WIDTH-1:0] col_r;
  logic [WIN-1:0][VALUE_WIDTH-1:0] col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (shift_en) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// ===== design/strict_local_minimum_3x3.sv =====
// ----------------------------------------------------------------------------
// strict_local_minimum_3x3
// Streaming 3x3 strict local minimum (valley) detector over a raster frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall in row-major order, one per transaction.
//   Frame size comes from cfg_wdata written to row_count (index 0) or
//   column_count (index 1); values are clamped to 3..MAX. Write only while idle.
//   For each interior pixel strictly below all eight neighbours one transaction
//   leaves on out_valid/out_stall with its 0-based position and nine values.
//   Border pixels never produce output; counters wrap after the last pixel so
//   frames follow back to back.
// Timing:
//   One pixel per cycle sustained unless a valley waits on out_stall. A result is
//   registered in the line-store read stage, then in the output register, after the
//   pixel that completes its window is accepted. The line store does one read and one write per cycle.
// Reset:
//   Synchronous, rst_n low clears counters, window and valids; sizes return to
//   3x3. Line-store contents are not cleared.
// Stall:
//   While out_stall holds a result, non-valley pixels keep flowing; the next
//   valley waits in the read stage and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module strict_local_minimum_3x3 #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [slm3_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [slm3_pkg::CFG_W-1:0]          cfg_wdata,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VALUE_WIDTH-1:0]       in_pixel_value,
  // valley output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [slm3_pkg::POS_W-1:0]          out_centre_row,
  output logic [slm3_pkg::POS_W-1:0]          out_centre_column,
  output logic signed [VALUE_WIDTH-1:0]       out_up_left,
  output logic signed [VALUE_WIDTH-1:0]       out_up_value,
  output logic signed [VALUE_WIDTH-1:0]       out_up_right,
  output logic signed [VALUE_WIDTH-1:0]       out_left_value,
  output logic signed [VALUE_WIDTH-1:0]       out_centre_value,
  output logic signed [VALUE_WIDTH-1:0]       out_right_value,
  output logic signed [VALUE_WIDTH-1:0]       out_down_left,
  output logic signed [VALUE_WIDTH-1:0]       out_down_value,
  output logic signed [VALUE_WIDTH-1:0]       out_down_right
);

  import slm3_pkg::*;

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  // frame size registers
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic [CCW-1:0] col_count_r, col_count_nxt;

  // position counters
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;

  // read stage
  logic                   s1_valid_r, s1_valid_nxt;
  logic [VALUE_WIDTH-1:0] s1_pix_r;
  logic [RW-1:0]          s1_row_r;
  logic [CW-1:0]          s1_col_r;
  logic [VALUE_WIDTH-1:0] rd_upper, rd_middle;

  // window chain
  logic [WIN-1:0][WIN-1:0][VALUE_WIDTH-1:0] cell_q;
  logic [WIN-1:0][WIN-1:0][VALUE_WIDTH-1:0] cell_d;
  logic [WIN-1:0][VALUE_WIDTH-1:0]          new_col;
  logic [WIN-1:0][WIN-1:0][VALUE_WIDTH-1:0] win;   // [row][column] after shift

  // output register
  logic                                     out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]                         out_row_r, out_col_r;
  logic [WIN-1:0][WIN-1:0][VALUE_WIDTH-1:0] out_win_r;

  logic accept;
  logic s1_fire;
  logic interior;
  logic nb_ok;
  logic valley;

  // ---------------------------------------------------------------- config
  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          if (32'(cfg_wdata) < WIN) row_count_nxt = RCW'(WIN);
          else if (32'(cfg_wdata) > MAX_ROWS) row_count_nxt = RCW'(MAX_ROWS);
          else row_count_nxt = RCW'(cfg_wdata);
        end
        REG_COLUMN_COUNT: begin
          if (32'(cfg_wdata) < WIN) col_count_nxt = CCW'(WIN);
          else if (32'(cfg_wdata) > MAX_COLUMNS) col_count_nxt = CCW'(MAX_COLUMNS);
          else col_count_nxt = CCW'(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  assign interior = (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
  assign valley   = interior && nb_ok;
  assign s1_fire  = s1_valid_r && (!valley || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign accept   = in_valid && !in_stall;

  // ------------------------------------------------------------- counters
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (accept) begin
      if ((CCW + 1)'(col_cnt_r) + 1'b1 >= (CCW + 1)'(col_count_r)) begin
        col_cnt_nxt = '0;
        if ((RCW + 1)'(row_cnt_r) + 1'b1 >= (RCW + 1)'(row_count_r)) begin
          row_cnt_nxt = '0;
        end else begin
          row_cnt_nxt = row_cnt_r + RW'(1);
        end
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= RCW'(WIN);
      col_count_r <= CCW'(WIN);
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel_value;
      s1_row_r <= row_cnt_r;
      s1_col_r <= col_cnt_r;
    end
  end

  // ----------------------------------------------------------- line store
  // column rolls upward: middle moves to upper, the new pixel becomes middle
  slm3_line_buf #(
    .DEPTH       (MAX_COLUMNS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col_cnt_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (s1_fire),
    .wr_addr   (s1_col_r),
    .wr_upper  (rd_middle),
    .wr_middle (s1_pix_r)
  );

  // --------------------------------------------------------- window chain
  assign new_col[0] = rd_upper;
  assign new_col[1] = rd_middle;
  assign new_col[2] = s1_pix_r;

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k == WIN - 1) begin : g_last
      assign cell_d[k] = new_col;
    end else begin : g_mid
      assign cell_d[k] = cell_q[k+1];
    end

    slm3_win_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_fire),
      .col_in   (cell_d[k]),
      .col_out  (cell_q[k])
    );
  end

  // window as it stands once the current column has shifted in
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        win[i][j] = cell_d[j][i];
      end
    end
  end

  always_comb begin
    nb_ok = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        if (!(i == CTR && j == CTR) &&
            $signed(win[CTR][CTR]) >= $signed(win[i][j])) begin
          nb_ok = 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- output
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && valley) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && valley) begin
      out_row_r <= POS_W'(s1_row_r - RW'(1));
      out_col_r <= POS_W'(s1_col_r - CW'(1));
      out_win_r <= win;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_centre_row    = out_row_r;
  assign out_centre_column = out_col_r;
  assign out_up_left       = out_win_r[0][0];
  assign out_up_value      = out_win_r[0][1];
  assign out_up_right      = out_win_r[0][2];
  assign out_left_value    = out_win_r[1][0];
  assign out_centre_value  = out_win_r[1][1];
  assign out_right_value   = out_win_r[1][2];
  assign out_down_left     = out_win_r[2][0];
  assign out_down_value    = out_win_r[2][1];
  assign out_down_right    = out_win_r[2][2];

  // ----------------------------------------------------------- assertions
  a_reset_counters: assert property (@(posedge clk)
    !rst_n |=> (row_cnt_r == '0 && col_cnt_r == '0 && !out_valid_r))
    else $error("counters not cleared by reset");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted transaction lost before the read stage");

  a_column_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> col_cnt_r != $past(col_cnt_r))
    else $error("column counter did not advance");

  a_result_is_valley: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_centre_value < out_up_left && out_centre_value < out_up_value &&
                   out_centre_value < out_up_right && out_centre_value < out_left_value &&
                   out_centre_value < out_right_value && out_centre_value < out_down_left &&
                   out_centre_value < out_down_value && out_centre_value < out_down_right))
    else $error("reported centre is not a strict minimum");

endmodule
